@@ rtl/sha256_pkg.sv @@
package sha256_pkg;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  valid_bytes;
        logic        last_word;
    } msg_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_done;
    } digest_beat_t;

    typedef enum logic [2:0] {
        SRC_DATA,
        SRC_PAD,
        SRC_ZERO,
        SRC_LEN_HI,
        SRC_LEN_LO
    } push_src_t;

    typedef struct packed {
        logic      push;
        push_src_t src;
        logic      count_bytes;
        logic      load_vars;
        logic      round;
        logic [5:0] round_idx;
        logic      add_chain;
        logic      shift_out;
        logic      restart;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic full;
    } dp_status_t;

    localparam logic [31:0] PAD_WORD = 32'h8000_0000;

    localparam logic [31:0] INITIAL_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

@@ rtl/sha256_dp.sv @@
module sha256_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sha256_pkg::msg_beat_t  msg_beat,
    input  sha256_pkg::dp_cmd_t    cmd,
    output sha256_pkg::dp_status_t status,
    output logic [31:0]           digest_word
);
    import sha256_pkg::*;

    logic [31:0] chain_reg [8];
    logic [31:0] chain_next [8];
    logic [31:0] vars_reg [8];
    logic [31:0] vars_next [8];
    logic [31:0] window_reg [16];
    logic [31:0] window_next [16];
    logic [31:0] bytes_reg;
    logic [31:0] bytes_next;
    logic [31:0] data_word;
    logic [31:0] push_word;
    logic [31:0] sched_word;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [2:0]  byte_add;

    assign status.last = msg_beat.last_word;
    assign status.full = msg_beat.valid_bytes[2];
    assign digest_word = chain_reg[0];

    always_comb
    begin
        if (!msg_beat.last_word || msg_beat.valid_bytes[2])
        begin
            data_word = msg_beat.data_word;
            byte_add  = 3'd4;
        end
        else
        begin
            byte_add = msg_beat.valid_bytes;
            unique case (msg_beat.valid_bytes[1:0])
                2'd0: data_word = PAD_WORD;
                2'd1: data_word = {msg_beat.data_word[31:24], 24'h800000};
                2'd2: data_word = {msg_beat.data_word[31:16], 16'h8000};
                2'd3: data_word = {msg_beat.data_word[31:8], 8'h80};
                default: data_word = PAD_WORD;
            endcase
        end
    end

    always_comb
    begin
        unique case (cmd.src)
            SRC_DATA:   push_word = data_word;
            SRC_PAD:    push_word = PAD_WORD;
            SRC_ZERO:   push_word = 32'd0;
            SRC_LEN_HI: push_word = {29'd0, bytes_reg[31:29]};
            SRC_LEN_LO: push_word = {bytes_reg[28:0], 3'b000};
            default:    push_word = 32'd0;
        endcase
    end

    assign sched_word = small_sigma1(window_reg[14]) + window_reg[9]
                        + small_sigma0(window_reg[1]) + window_reg[0];

    assign t1 = vars_reg[7] + big_sigma1(vars_reg[4])
                + ((vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]))
                + ROUND_CONST[cmd.round_idx] + window_reg[0];
    assign t2 = big_sigma0(vars_reg[0])
                + ((vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
                   ^ (vars_reg[1] & vars_reg[2]));

    always_comb
    begin
        window_next = window_reg;
        if (cmd.push || cmd.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                window_next[i] = window_reg[i + 1];
            end
            window_next[15] = cmd.push ? push_word : sched_word;
        end

        vars_next = vars_reg;
        if (cmd.load_vars)
        begin
            vars_next = chain_reg;
        end
        else if (cmd.round)
        begin
            vars_next[7] = vars_reg[6];
            vars_next[6] = vars_reg[5];
            vars_next[5] = vars_reg[4];
            vars_next[4] = vars_reg[3] + t1;
            vars_next[3] = vars_reg[2];
            vars_next[2] = vars_reg[1];
            vars_next[1] = vars_reg[0];
            vars_next[0] = t1 + t2;
        end

        chain_next = chain_reg;
        priority if (cmd.restart)
        begin
            chain_next = INITIAL_HASH;
        end
        else if (cmd.add_chain)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_next[i] = chain_reg[i] + vars_reg[i];
            end
        end
        else if (cmd.shift_out)
        begin
            for (int i = 0; i < 7; i++)
            begin
                chain_next[i] = chain_reg[i + 1];
            end
            chain_next[7] = chain_reg[0];
        end

        bytes_next = bytes_reg;
        if (cmd.restart)
        begin
            bytes_next = 32'd0;
        end
        else if (cmd.count_bytes)
        begin
            bytes_next = bytes_reg + {29'd0, byte_add};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= INITIAL_HASH;
            bytes_reg <= 32'd0;
        end
        else
        begin
            chain_reg <= chain_next;
            bytes_reg <= bytes_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vars_reg   <= vars_next;
        window_reg <= window_next;
    end

endmodule

@@ rtl/sha256_ctrl.sv @@
module sha256_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  msg_valid,
    output logic                  msg_stall,
    output logic                  dig_valid,
    input  logic                  dig_stall,
    output logic [2:0]            word_index,
    output logic                  digest_done,
    input  sha256_pkg::dp_status_t status,
    output sha256_pkg::dp_cmd_t    cmd
);
    import sha256_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  pos_reg, pos_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  index_reg, index_next;
    logic        finishing_reg, finishing_next;
    logic        pad_reg, pad_next;
    logic        hi_done_reg, hi_done_next;
    logic        emit_reg, emit_next;
    logic        dig_valid_reg, dig_valid_next;
    logic        msg_accept;
    logic        dig_accept;

    assign msg_stall   = (state_reg != ST_IDLE);
    assign msg_accept  = msg_valid && (state_reg == ST_IDLE);
    assign dig_valid   = dig_valid_reg;
    assign dig_accept  = dig_valid_reg && !dig_stall;
    assign word_index  = index_reg;
    assign digest_done = (index_reg == 3'd7);

    always_comb
    begin
        cmd            = '0;
        cmd.src        = SRC_DATA;
        cmd.round_idx  = round_reg;
        state_next     = state_reg;
        pos_next       = pos_reg;
        round_next     = round_reg;
        index_next     = index_reg;
        finishing_next = finishing_reg;
        pad_next       = pad_reg;
        hi_done_next   = hi_done_reg;
        emit_next      = emit_reg;
        dig_valid_next = dig_valid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_accept)
                begin
                    cmd.push        = 1'b1;
                    cmd.count_bytes = 1'b1;
                    pos_next        = pos_reg + 4'd1;
                    if (status.last)
                    begin
                        finishing_next = 1'b1;
                        pad_next       = status.full;
                        hi_done_next   = 1'b0;
                        emit_next      = 1'b0;
                    end
                    if (pos_reg == 4'd15)
                    begin
                        cmd.load_vars = 1'b1;
                        round_next    = 6'd0;
                        state_next    = ST_ROUND;
                    end
                    else if (status.last)
                    begin
                        state_next = ST_FILL;
                    end
                end
            end
            ST_FILL:
            begin
                cmd.push = 1'b1;
                pos_next = pos_reg + 4'd1;
                priority if (pad_reg)
                begin
                    cmd.src  = SRC_PAD;
                    pad_next = 1'b0;
                end
                else if (hi_done_reg)
                begin
                    cmd.src   = SRC_LEN_LO;
                    emit_next = 1'b1;
                end
                else if (pos_reg == 4'd14)
                begin
                    cmd.src      = SRC_LEN_HI;
                    hi_done_next = 1'b1;
                end
                else
                begin
                    cmd.src = SRC_ZERO;
                end
                if (pos_reg == 4'd15)
                begin
                    cmd.load_vars = 1'b1;
                    round_next    = 6'd0;
                    state_next    = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.round  = 1'b1;
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                cmd.add_chain = 1'b1;
                priority if (emit_reg)
                begin
                    index_next     = 3'd0;
                    dig_valid_next = 1'b1;
                    state_next     = ST_EMIT;
                end
                else if (finishing_reg)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (dig_accept)
                begin
                    cmd.shift_out = 1'b1;
                    index_next    = index_reg + 3'd1;
                    if (index_reg == 3'd7)
                    begin
                        cmd.restart    = 1'b1;
                        dig_valid_next = 1'b0;
                        finishing_next = 1'b0;
                        emit_next      = 1'b0;
                        hi_done_next   = 1'b0;
                        pos_next       = 4'd0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= 4'd0;
            round_reg     <= 6'd0;
            index_reg     <= 3'd0;
            finishing_reg <= 1'b0;
            pad_reg       <= 1'b0;
            hi_done_reg   <= 1'b0;
            emit_reg      <= 1'b0;
            dig_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            round_reg     <= round_next;
            index_reg     <= index_next;
            finishing_reg <= finishing_next;
            pad_reg       <= pad_next;
            hi_done_reg   <= hi_done_next;
            emit_reg      <= emit_next;
            dig_valid_reg <= dig_valid_next;
        end
    end

endmodule

@@ rtl/sha256_hash_core.sv @@
// SHA-256 hash core.
// The message channel (msg_valid, msg_stall, msg_beat) takes one big-endian word per
// beat; valid_bytes is honored only on the beat with last_word set. The digest channel
// (dig_valid, dig_stall, dig_beat) returns eight beats, word_index 0 to 7, with
// digest_done on the eighth.
// A message beat is taken while msg_stall is low. Every sixteenth word starts a
// compression that holds msg_stall high: 64 rounds through the single round unit,
// then a fold of the result into the chaining hash. After the last word the padding,
// zero fill and length words are pushed one per cycle except while a compression runs;
// one or two compressions run in all, and the first digest beat appears when the last
// of them has folded its result into the chaining hash.
// While the receiver stalls, the digest beat holds and no message beat is taken; the
// initial hash is reloaded when the eighth digest beat is taken.
// Reset loads the initial hash, clears the byte count and returns to the idle state.
module sha256_hash_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      msg_valid,
    output logic                      msg_stall,
    input  sha256_pkg::msg_beat_t     msg_beat,
    output logic                      dig_valid,
    input  logic                      dig_stall,
    output sha256_pkg::digest_beat_t  dig_beat
);
    import sha256_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_done;

    sha256_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .msg_valid   (msg_valid),
        .msg_stall   (msg_stall),
        .dig_valid   (dig_valid),
        .dig_stall   (dig_stall),
        .word_index  (word_index),
        .digest_done (digest_done),
        .status      (status),
        .cmd         (cmd)
    );

    sha256_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .msg_beat    (msg_beat),
        .cmd         (cmd),
        .status      (status),
        .digest_word (digest_word)
    );

    assign dig_beat.digest_word = digest_word;
    assign dig_beat.word_index  = word_index;
    assign dig_beat.digest_done = digest_done;

endmodule
